@@ hw/rtl/mcdr_pkg.sv @@
`default_nettype none

package mcdr_pkg;

    // channel set and per-channel delay
    localparam int NUM_CH     = 8;
    localparam int CH_BITS    = 3;
    localparam int DELAY_BITS = 16;

    // results per item are capped on a tick
    localparam int MAX_RESULTS  = 16;
    localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

    // defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 32;

    // configuration port
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    // input op codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    // result kinds
    localparam logic KIND_FIRED   = 1'b0;
    localparam logic KIND_DROPPED = 1'b1;

    typedef logic [NUM_CH-1:0][DELAY_BITS-1:0] delay_arr_t;

endpackage

`default_nettype wire

@@ hw/rtl/multi_channel_delayed_relay.sv @@
// Multi-channel delayed relay.
// Command channel: an item (op, enabled) is taken at a rising edge with start
// high and busy low. op = trigger walks channels 0..7, one per cycle: a zero
// delay fires at once, otherwise now + delay is stored in the pending table,
// or a drop result is given when the table is full. A disabled trigger skips
// the walk: it gives nothing, changes nothing and is busy for one cycle.
// op = tick adds one to the running time, then scans the table in order, one
// entry per cycle through the table RAM's registered read port, firing and
// removing every entry whose deadline has passed, up to MAX_RESULTS per tick,
// and compacting the rest. Busy time is set by the channel walk of a trigger
// and by the table scan of a tick, which grows with the number of pending
// entries. Results come out one per cycle on channel/kind/last, marked by
// strobe, held back by one beat so the final beat of an item carries last;
// the final beat may come in the cycle after busy falls. The receiver cannot
// stall the result beats. Delays are written over the APB port only while
// the block is idle, a rule for the user that the block does not enforce.
// Reset clears the running time, empties the table and zeroes all delays.
`default_nettype none

module multi_channel_delayed_relay
    import mcdr_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // command channel
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     op,
    input  wire logic                     enabled,
    // result channel
    output logic                          strobe,
    output logic      [CH_BITS-1:0]       channel,
    output logic                          kind,
    output logic                          last,
    // configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = CH_BITS + TIME_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_ADV,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           keep_reg;
    logic [AW-1:0]           scan_idx_reg;
    logic [CH_BITS-1:0]      ch_cnt_reg;
    logic [RES_CNT_BITS-1:0] n_cnt_reg;
    logic                    hold_valid_reg;
    logic [CH_BITS-1:0]      hold_ch_reg;
    logic                    hold_kind_reg;
    logic                    strobe_reg;
    logic [CH_BITS-1:0]      channel_reg;
    logic                    kind_reg;
    logic                    last_reg;

    delay_arr_t              delay;
    logic [DELAY_BITS-1:0]   delay_sel;
    logic                    table_full;

    logic [TIME_BITS-1:0]    alu_b;
    logic                    alu_sub;
    logic [TIME_BITS-1:0]    alu_sum;
    logic                    alu_past;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [EW-1:0]           ram_rdata;
    logic [CH_BITS-1:0]      rd_ch;
    logic [TIME_BITS-1:0]    rd_deadline;

    logic                    new_res;
    logic [CH_BITS-1:0]      new_ch;
    logic                    new_kind;
    logic                    fire;
    logic                    scan_last;
    logic [CW-1:0]           keep_next;

    // configuration registers
    mcdr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .delay   (delay)
    );

    // pending table: {channel, deadline}
    mcdr_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared time adder / comparator
    mcdr_alu #(
        .W (TIME_BITS)
    ) u_alu (
        .a    (now_reg),
        .b    (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .past (alu_past)
    );

    assign rd_ch       = ram_rdata[EW-1:TIME_BITS];
    assign rd_deadline = ram_rdata[TIME_BITS-1:0];
    assign delay_sel   = delay[ch_cnt_reg];
    assign table_full  = (count_reg == CW'(TABLE_DEPTH));
    assign scan_last   = ((CW'(scan_idx_reg) + CW'(1)) == count_reg);
    assign fire        = alu_past && (n_cnt_reg < RES_CNT_BITS'(MAX_RESULTS));

    // adder operand select
    always_comb
    begin
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_TRIG:
            begin
                alu_b = TIME_BITS'(delay_sel);
            end
            S_ADV:
            begin
                alu_b = TIME_BITS'(1);
            end
            S_SCAN:
            begin
                alu_b   = rd_deadline;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_b = '0;
            end
        endcase
    end

    // table write and new result per step
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {ch_cnt_reg, alu_sum};
        ram_raddr = scan_idx_reg + AW'(1);
        new_res   = 1'b0;
        new_ch    = ch_cnt_reg;
        new_kind  = KIND_FIRED;
        keep_next = keep_reg;
        case (state_reg)
            S_TRIG:
            begin
                if (delay_sel == '0)
                begin
                    new_res = 1'b1;
                end
                else if (table_full)
                begin
                    new_res  = 1'b1;
                    new_kind = KIND_DROPPED;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            S_ADV:
            begin
                ram_raddr = '0;
            end
            S_SCAN:
            begin
                ram_waddr = keep_reg[AW-1:0];
                ram_wdata = ram_rdata;
                new_ch    = rd_ch;
                if (fire)
                begin
                    new_res = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    keep_next = keep_reg + CW'(1);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer, table state and result beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            count_reg      <= '0;
            keep_reg       <= '0;
            scan_idx_reg   <= '0;
            ch_cnt_reg     <= '0;
            n_cnt_reg      <= '0;
            hold_valid_reg <= 1'b0;
            hold_ch_reg    <= '0;
            hold_kind_reg  <= KIND_FIRED;
            strobe_reg     <= 1'b0;
            channel_reg    <= '0;
            kind_reg       <= KIND_FIRED;
            last_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;

            // one-beat holdback so the final beat can carry last
            if (new_res)
            begin
                n_cnt_reg      <= n_cnt_reg + RES_CNT_BITS'(1);
                hold_valid_reg <= 1'b1;
                hold_ch_reg    <= new_ch;
                hold_kind_reg  <= new_kind;
                if (hold_valid_reg)
                begin
                    strobe_reg  <= 1'b1;
                    channel_reg <= hold_ch_reg;
                    kind_reg    <= hold_kind_reg;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    n_cnt_reg    <= '0;
                    ch_cnt_reg   <= '0;
                    keep_reg     <= '0;
                    scan_idx_reg <= '0;
                    if (start)
                    begin
                        if (op == OP_TICK)
                        begin
                            state_reg <= S_ADV;
                        end
                        else if (enabled)
                        begin
                            state_reg <= S_TRIG;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_TRIG:
                begin
                    if (ram_we)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    ch_cnt_reg <= ch_cnt_reg + CH_BITS'(1);
                    if (ch_cnt_reg == CH_BITS'(NUM_CH - 1))
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_ADV:
                begin
                    now_reg <= alu_sum;
                    if (count_reg == '0)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    keep_reg     <= keep_next;
                    scan_idx_reg <= scan_idx_reg + AW'(1);
                    if (scan_last)
                    begin
                        count_reg <= keep_next;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (hold_valid_reg)
                    begin
                        strobe_reg  <= 1'b1;
                        channel_reg <= hold_ch_reg;
                        kind_reg    <= hold_kind_reg;
                        last_reg    <= 1'b1;
                    end
                    hold_valid_reg <= 1'b0;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign channel = channel_reg;
    assign kind    = kind_reg;
    assign last    = last_reg;

    // table fill never exceeds its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("pending count beyond table depth");

    // the closing beat of an item is not followed straight by another beat
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |=> !strobe_reg)
        else $error("result beat right after closing beat");

    // a drop is only reported with the table full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (kind_reg == KIND_DROPPED)) |-> table_full)
        else $error("drop reported with room in table");

    // table fill holds while idle and no item arrives
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> $stable(count_reg))
        else $error("pending count changed while idle");

endmodule

`default_nettype wire

@@ hw/rtl/mcdr_ram.sv @@
`default_nettype none

module mcdr_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/mcdr_regs.sv @@
`default_nettype none

module mcdr_regs
    import mcdr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output delay_arr_t                    delay
);

    delay_arr_t         delay_reg;
    logic [CH_BITS-1:0] reg_idx;
    logic               wr_en;

    // word index: register i sits at byte address 4*i
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
        end
        else if (wr_en)
        begin
            delay_reg[reg_idx] <= pwdata[DELAY_BITS-1:0];
        end
    end

    // read back
    assign prdata = {{(APB_DATA_BITS-DELAY_BITS){1'b0}}, delay_reg[reg_idx]};
    assign delay  = delay_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mcdr_alu.sv @@
`default_nettype none

module mcdr_alu #(
    parameter int W = 32
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic         sub,
    output logic      [W-1:0] sum,
    output logic              past
);

    // shared adder: a + b, or a - b through inverted operand and carry in
    assign sum = a + (sub ? ~b : b) + W'(sub);

    // serial-number compare: nonzero and below half range
    assign past = (sum != '0) && !sum[W-1];

endmodule

`default_nettype wire
